// File: design/bdrl_pkg.sv
// ----------------------------------------------------------------------------
// bdrl_pkg
// Shared types and constants for the button debounce / repeat / long press
// block: item structs, key codes, opcodes, register indexes, queue sizing.
// ----------------------------------------------------------------------------
package bdrl_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_BTN  = 3;
    localparam int BTN_UP   = 0;
    localparam int BTN_DOWN = 1;
    localparam int BTN_PUSH = 2;

    localparam logic OP_POLL   = 1'b0;
    localparam logic OP_INJECT = 1'b1;

    localparam logic [2:0] KEY_NONE  = 3'd0;
    localparam logic [2:0] KEY_UP    = 3'd1;
    localparam logic [2:0] KEY_DOWN  = 3'd2;
    localparam logic [2:0] KEY_PUSH  = 3'd3;
    localparam logic [2:0] KEY_LONG  = 3'd4;
    localparam logic [2:0] KEY_SLEEP = 3'd5;

    localparam logic [2:0] CFG_DEBOUNCE = 3'd0;
    localparam logic [2:0] CFG_RPT_DLY  = 3'd1;
    localparam logic [2:0] CFG_RPT_PER  = 3'd2;
    localparam logic [2:0] CFG_LONG     = 3'd3;
    localparam logic [2:0] CFG_SLEEP    = 3'd4;

    localparam logic [9:0]  RST_DEBOUNCE = 10'd25;
    localparam logic [15:0] RST_RPT_DLY  = 16'd450;
    localparam logic [15:0] RST_RPT_PER  = 16'd150;
    localparam logic [15:0] RST_LONG     = 16'd1000;
    localparam logic [15:0] RST_SLEEP    = 16'd3000;

    typedef struct packed {
        logic        opcode;
        logic [31:0] now_ms;
        logic        raw_up;
        logic        raw_down;
        logic        raw_push;
        logic [2:0]  inject_key;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  key_event;
        logic [31:0] last_activity_ms;
        logic [31:0] push_hold_ms;
    } t_out_item;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] key;
    } t_q_req;

endpackage

// File: design/bdrl_key_queue.sv
// ----------------------------------------------------------------------------
// bdrl_key_queue
// Ring of injected keys held in a synchronous memory. Head and count are
// updated at request time; popped data is registered and appears in the cycle after the pop.
// ----------------------------------------------------------------------------
module bdrl_key_queue
    import bdrl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_req     i_req,
    output logic       o_pop,
    output logic [2:0] o_rdata
);

    logic [2:0]          r_mem [QUEUE_DEPTH];
    logic [2:0]          r_rdata;
    logic [QUEUE_AW-1:0] r_head;
    logic [QUEUE_CW-1:0] r_count;

    logic [QUEUE_AW:0]   w_tail_sum;
    logic [QUEUE_AW-1:0] w_tail;
    logic [QUEUE_AW-1:0] w_head_inc;
    logic                w_full;
    logic                w_key_ok;
    logic                w_wr;
    logic                w_rd;

    assign w_full     = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign w_key_ok   = (i_req.key != KEY_NONE) && (i_req.key <= KEY_SLEEP);
    assign w_wr       = i_req.push && w_key_ok && !w_full;
    assign w_rd       = i_req.pop && (r_count != '0);
    assign w_tail_sum = (QUEUE_AW + 1)'(r_head) + (QUEUE_AW + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= (QUEUE_AW + 1)'(QUEUE_DEPTH))
                        ? QUEUE_AW'(w_tail_sum - (QUEUE_AW + 1)'(QUEUE_DEPTH))
                        : QUEUE_AW'(w_tail_sum);
    assign w_head_inc = (r_head == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_tail] <= i_req.key;
        end
        if (w_rd) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (w_rd) begin
                r_head  <= w_head_inc;
                r_count <= r_count - 1'b1;
            end else if (w_wr) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_pop   = w_rd;
    assign o_rdata = r_rdata;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("key queue count above depth");

    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr && w_rd))
        else $error("key queue write and read in one cycle");

endmodule

// File: design/button_debounce_repeat_longpress_top.sv
// ----------------------------------------------------------------------------
// button_debounce_repeat_longpress_top
// Three-button front end: debounce, auto-repeat of up/down, push / long push
// on release, sleep hold while held, and a queue of injected keys.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_item
//  out      | output    | o_out_valid / i_out_ready | o_out_item
//  cfg      | input     | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
//
// One item per cycle while the output is not stalled. The accepting edge
// reads the key queue memory and registers the item; the buttons are then
// scanned from that register, and the result is loaded into the output register when it can advance.
// Reset is synchronous, no clearing pass.
// A stalled output holds the second stage, which holds off new items.
// ----------------------------------------------------------------------------
module button_debounce_repeat_longpress_top
    import bdrl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    logic [9:0]  r_debounce;
    logic [15:0] r_rpt_dly;
    logic [15:0] r_rpt_per;
    logic [15:0] r_long;
    logic [15:0] r_sleep;

    logic        r_raw    [NUM_BTN];
    logic        r_stable [NUM_BTN];
    logic        r_lf     [NUM_BTN];
    logic [31:0] r_chg    [NUM_BTN];
    logic [31:0] r_press  [NUM_BTN];
    logic [31:0] r_rep    [NUM_BTN];
    logic [31:0] r_act;

    logic        n_raw    [NUM_BTN];
    logic        n_stable [NUM_BTN];
    logic        n_lf     [NUM_BTN];
    logic [31:0] n_chg    [NUM_BTN];
    logic [31:0] n_press  [NUM_BTN];
    logic [31:0] n_rep    [NUM_BTN];
    logic [31:0] n_act;

    logic        r_s1_valid;
    t_in_item    r_s1_item;
    logic        r_s1_pop;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    t_q_req      w_q_req;
    logic        w_q_pop;
    logic [2:0]  w_q_rdata;
    logic        w_in_acc;
    logic        w_s1_adv;
    logic        w_s1_fire;
    logic [NUM_BTN-1:0] w_lvl;
    logic [2:0]  w_ev;

    assign w_s1_adv   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_s1_fire  = r_s1_valid && w_s1_adv;

    assign w_q_req.push = w_in_acc && (i_in_item.opcode == OP_INJECT);
    assign w_q_req.pop  = w_in_acc && (i_in_item.opcode == OP_POLL);
    assign w_q_req.key  = i_in_item.inject_key;

    bdrl_key_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_q_req),
        .o_pop   (w_q_pop),
        .o_rdata (w_q_rdata)
    );

    assign w_lvl = {r_s1_item.raw_push, r_s1_item.raw_down, r_s1_item.raw_up};

    always_comb begin
        logic        done;
        logic        lvl;
        logic [31:0] now;
        now      = r_s1_item.now_ms;
        done     = 1'b0;
        lvl      = 1'b0;
        n_raw    = r_raw;
        n_stable = r_stable;
        n_lf     = r_lf;
        n_chg    = r_chg;
        n_press  = r_press;
        n_rep    = r_rep;
        n_act    = r_act;
        w_ev     = KEY_NONE;
        if (w_s1_fire && (r_s1_item.opcode == OP_POLL)) begin
            if (r_s1_pop) begin
                w_ev  = w_q_rdata;
                n_act = now;
            end else begin
                for (int b = 0; b < NUM_BTN; b++) begin
                    if (!done) begin
                        lvl = w_lvl[b];
                        if (lvl != n_raw[b]) begin
                            n_raw[b] = lvl;
                            n_chg[b] = now;
                        end
                        if ((lvl != n_stable[b]) &&
                            ((now - n_chg[b]) >= 32'(r_debounce))) begin
                            n_stable[b] = lvl;
                            n_act       = now;
                            if (lvl) begin
                                n_press[b] = now;
                                n_rep[b]   = now + 32'(r_rpt_dly);
                                n_lf[b]    = 1'b0;
                                if (b != BTN_PUSH) begin
                                    w_ev = (b == BTN_UP) ? KEY_UP : KEY_DOWN;
                                    done = 1'b1;
                                end
                            end else if ((b == BTN_PUSH) && !n_lf[b]) begin
                                w_ev = ((now - n_press[b]) >= 32'(r_long)) ? KEY_LONG
                                                                          : KEY_PUSH;
                                done = 1'b1;
                            end
                        end
                        if (!done && n_stable[b]) begin
                            if (b == BTN_PUSH) begin
                                if (!n_lf[b] && ((now - n_press[b]) >= 32'(r_sleep))) begin
                                    n_lf[b] = 1'b1;
                                    n_act   = now;
                                    w_ev    = KEY_SLEEP;
                                    done    = 1'b1;
                                end
                            end else if (now >= n_rep[b]) begin
                                n_rep[b] = now + 32'(r_rpt_per);
                                n_act    = now;
                                w_ev     = (b == BTN_UP) ? KEY_UP : KEY_DOWN;
                                done     = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        n_out_item.key_event        = w_ev;
        n_out_item.last_activity_ms = n_act;
        n_out_item.push_hold_ms     = (n_stable[BTN_PUSH] && !n_lf[BTN_PUSH])
                                      ? now - n_press[BTN_PUSH] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= RST_DEBOUNCE;
            r_rpt_dly  <= RST_RPT_DLY;
            r_rpt_per  <= RST_RPT_PER;
            r_long     <= RST_LONG;
            r_sleep    <= RST_SLEEP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE: r_debounce <= i_cfg_wdata[9:0];
                CFG_RPT_DLY:  r_rpt_dly  <= i_cfg_wdata;
                CFG_RPT_PER:  r_rpt_per  <= i_cfg_wdata;
                CFG_LONG:     r_long     <= i_cfg_wdata;
                CFG_SLEEP:    r_sleep    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                r_raw[b]    <= 1'b0;
                r_stable[b] <= 1'b0;
                r_lf[b]     <= 1'b0;
                r_chg[b]    <= '0;
                r_press[b]  <= '0;
                r_rep[b]    <= '0;
            end
            r_act       <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_pop    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_lf     <= n_lf;
            r_chg    <= n_chg;
            r_press  <= n_press;
            r_rep    <= n_rep;
            r_act    <= n_act;
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
                r_s1_pop   <= w_q_pop;
            end
            if (w_s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_item <= i_in_item;
        end
        if (w_s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_pop_is_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_pop) |-> (r_s1_item.opcode == OP_POLL))
        else $error("queue pop tagged on inject item");

    a_inject_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && (r_s1_item.opcode == OP_INJECT)) |=>
        (o_out_item.key_event == KEY_NONE))
        else $error("inject item produced a key event");

    a_hold_needs_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.push_hold_ms != 32'd0)) |->
        (r_stable[BTN_PUSH] && !r_lf[BTN_PUSH]))
        else $error("push hold time reported while push not held");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("item accepted into a stalled pipeline");

endmodule
